/* src/pltf_pkg.sv */
// Shared types and constants for the polyline turn-angle vertex filter.
// Used by every module of the block but the queue; depends on nothing.
package pltf_pkg;

  // Width of the min_turn configuration register.
  localparam int unsigned MIN_TURN_W = 16;

  // Number of CORDIC vectoring stages.
  localparam int unsigned TURN_ITERS = 28;

  // Angles inside the CORDIC are 32-bit fractions of a full turn.
  localparam int unsigned ZW = 32;
  localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

  // Entries between the CORDIC pipeline and the decision stage (a power of two).
  localparam int unsigned QUEUE_DEPTH = 4;

  // Role of a vertex within its polygon, fixed when the vertex is accepted.
  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_SECOND,
    KIND_LATER
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  last;
    logic  zero;
  } ctl_t;

  // atan(2^-i) as a fraction of a full turn.
  function automatic logic [ZW-1:0] atan_entry(input int unsigned idx);
    logic [ZW-1:0] val;
    unique case (idx)
      0:       val = 32'h2000_0000;
      1:       val = 32'h12E4_051E;
      2:       val = 32'h09FB_385B;
      3:       val = 32'h0511_11D4;
      4:       val = 32'h028B_0D43;
      5:       val = 32'h0145_D7E1;
      6:       val = 32'h00A2_F61E;
      7:       val = 32'h0051_7C55;
      8:       val = 32'h0028_BE53;
      9:       val = 32'h0014_5F2F;
      10:      val = 32'h000A_2F98;
      11:      val = 32'h0005_17CC;
      12:      val = 32'h0002_8BE6;
      13:      val = 32'h0001_45F3;
      14:      val = 32'h0000_A2FA;
      15:      val = 32'h0000_517D;
      16:      val = 32'h0000_28BE;
      17:      val = 32'h0000_145F;
      18:      val = 32'h0000_0A30;
      19:      val = 32'h0000_0518;
      20:      val = 32'h0000_028C;
      21:      val = 32'h0000_0146;
      22:      val = 32'h0000_00A3;
      23:      val = 32'h0000_0051;
      24:      val = 32'h0000_0029;
      25:      val = 32'h0000_0014;
      26:      val = 32'h0000_000A;
      27:      val = 32'h0000_0005;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* src/pltf_front.sv */
// Front end: accepts vertices, tracks the previous point and polygon phase,
// and registers the folded difference vector that enters the CORDIC. Uses pltf_pkg.
module pltf_front #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned CW          = COORD_WIDTH + 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          in_valid_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  logic                          polygon_end_i,
  output logic                          s0_valid_o,
  output logic signed [CW-1:0]          s0_x_o,
  output logic signed [CW-1:0]          s0_y_o,
  output logic [pltf_pkg::ZW-1:0]       s0_z_o,
  output pltf_pkg::ctl_t                s0_ctl_o,
  output logic [COORD_WIDTH-1:0]        s0_px_o,
  output logic [COORD_WIDTH-1:0]        s0_py_o
);
  import pltf_pkg::*;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_ONE  = 2'd1;
  localparam logic [1:0] PH_MORE = 2'd2;

  logic [1:0]                   phase_q, phase_d;
  logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
  logic                         accept;
  logic signed [COORD_WIDTH:0]  dx_w, dy_w;
  logic signed [CW-1:0]         dx_e, dy_e;
  ctl_t                         ctl_w;

  logic                         valid_q;
  logic signed [CW-1:0]         x_q, y_q;
  logic [ZW-1:0]                z_q;
  ctl_t                         ctl_q;
  logic [COORD_WIDTH-1:0]       px_q, py_q;

  assign accept = in_valid_i && adv_i;

  always_comb begin
    dx_w = $signed({prev_x_q[COORD_WIDTH-1], prev_x_q})
         - $signed({vertex_x_i[COORD_WIDTH-1], vertex_x_i});
    dy_w = $signed({prev_y_q[COORD_WIDTH-1], prev_y_q})
         - $signed({vertex_y_i[COORD_WIDTH-1], vertex_y_i});
    dx_e = CW'(dx_w);
    dy_e = CW'(dy_w);
    ctl_w.last = polygon_end_i;
    ctl_w.zero = (dx_w == '0) && (dy_w == '0);
    unique case (phase_q)
      PH_NONE: ctl_w.kind = KIND_FIRST;
      PH_ONE:  ctl_w.kind = KIND_SECOND;
      default: ctl_w.kind = KIND_LATER;
    endcase
    if (polygon_end_i) begin
      phase_d = PH_NONE;
    end else if (phase_q == PH_NONE) begin
      phase_d = PH_ONE;
    end else begin
      phase_d = PH_MORE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_NONE;
      prev_x_q <= '0;
      prev_y_q <= '0;
      valid_q  <= 1'b0;
    end else if (adv_i) begin
      valid_q <= in_valid_i;
      if (accept) begin
        phase_q  <= phase_d;
        prev_x_q <= polygon_end_i ? '0 : vertex_x_i;
        prev_y_q <= polygon_end_i ? '0 : vertex_y_i;
      end
    end
  end

  // A difference pointing into the left half plane is rotated by a half turn.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (dx_w[COORD_WIDTH]) begin
        x_q <= -dx_e;
        y_q <= -dy_e;
        z_q <= HALF_TURN;
      end else begin
        x_q <= dx_e;
        y_q <= dy_e;
        z_q <= '0;
      end
      ctl_q <= ctl_w;
      px_q  <= vertex_x_i;
      py_q  <= vertex_y_i;
    end
  end

  assign s0_valid_o = valid_q;
  assign s0_x_o     = x_q;
  assign s0_y_o     = y_q;
  assign s0_z_o     = z_q;
  assign s0_ctl_o   = ctl_q;
  assign s0_px_o    = px_q;
  assign s0_py_o    = py_q;

endmodule

/* src/pltf_cordic.sv */
// Pipelined CORDIC in vectoring mode, one iteration per stage, with rounding
// of the final angle. Carries the vertex and its control along. Uses pltf_pkg.
module pltf_cordic #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned ANGLE_WIDTH = 16,
  parameter int unsigned CW          = COORD_WIDTH + 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    s0_valid_i,
  input  logic signed [CW-1:0]    s0_x_i,
  input  logic signed [CW-1:0]    s0_y_i,
  input  logic [pltf_pkg::ZW-1:0] s0_z_i,
  input  pltf_pkg::ctl_t          s0_ctl_i,
  input  logic [COORD_WIDTH-1:0]  s0_px_i,
  input  logic [COORD_WIDTH-1:0]  s0_py_i,
  output logic                    c_valid_o,
  output logic [ANGLE_WIDTH-1:0]  c_angle_o,
  output pltf_pkg::ctl_t          c_ctl_o,
  output logic [COORD_WIDTH-1:0]  c_px_o,
  output logic [COORD_WIDTH-1:0]  c_py_o
);
  import pltf_pkg::*;

  localparam int unsigned N = TURN_ITERS;
  localparam logic [ZW-1:0] ZRND = ZW'(1) << (ZW - 1 - ANGLE_WIDTH);

  logic                   v_q   [N];
  logic signed [CW-1:0]   x_q   [N];
  logic signed [CW-1:0]   y_q   [N];
  logic [ZW-1:0]          z_q   [N];
  ctl_t                   ctl_q [N];
  logic [COORD_WIDTH-1:0] px_q  [N];
  logic [COORD_WIDTH-1:0] py_q  [N];

  logic signed [CW-1:0]   x_src [N];
  logic signed [CW-1:0]   y_src [N];
  logic [ZW-1:0]          z_src [N];
  logic signed [CW-1:0]   x_d   [N];
  logic signed [CW-1:0]   y_d   [N];
  logic [ZW-1:0]          z_d   [N];
  logic [ZW-1:0]          z_rnd;

  // Each stage works on its own pair of registers; the loop builds N stages.
  always_comb begin
    x_src[0] = s0_x_i;
    y_src[0] = s0_y_i;
    z_src[0] = s0_z_i;
    for (int i = 1; i < N; i++) begin
      x_src[i] = x_q[i-1];
      y_src[i] = y_q[i-1];
      z_src[i] = z_q[i-1];
    end
    for (int i = 0; i < N; i++) begin
      if (!y_src[i][CW-1]) begin
        x_d[i] = x_src[i] + (y_src[i] >>> i);
        y_d[i] = y_src[i] - (x_src[i] >>> i);
        z_d[i] = z_src[i] + atan_entry(i);
      end else begin
        x_d[i] = x_src[i] - (y_src[i] >>> i);
        y_d[i] = y_src[i] + (x_src[i] >>> i);
        z_d[i] = z_src[i] - atan_entry(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (adv_i) begin
      v_q[0] <= s0_valid_i;
      for (int i = 1; i < N; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < N; i++) begin
        x_q[i] <= x_d[i];
        y_q[i] <= y_d[i];
        z_q[i] <= z_d[i];
      end
      ctl_q[0] <= s0_ctl_i;
      px_q[0]  <= s0_px_i;
      py_q[0]  <= s0_py_i;
      for (int i = 1; i < N; i++) begin
        ctl_q[i] <= ctl_q[i-1];
        px_q[i]  <= px_q[i-1];
        py_q[i]  <= py_q[i-1];
      end
    end
  end

  // Round to the output angle width; a zero vector has angle zero.
  assign z_rnd     = z_q[N-1] + ZRND;
  assign c_valid_o = v_q[N-1];
  assign c_angle_o = ctl_q[N-1].zero ? '0 : z_rnd[ZW-1 -: ANGLE_WIDTH];
  assign c_ctl_o   = ctl_q[N-1];
  assign c_px_o    = px_q[N-1];
  assign c_py_o    = py_q[N-1];

endmodule

/* src/pltf_queue.sv */
// Small FIFO that decouples the CORDIC pipeline from the decision stage.
// Register-based storage; depends on nothing else.
module pltf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             not_empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]  count_q;

  assign full_o      = (count_q == CNTW'(DEPTH));
  assign not_empty_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNTW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/pltf_back.sv */
// Back end: compares each angle with the reference angle, decides keep or
// drop, and holds the result in an output register. Uses pltf_pkg.
module pltf_back #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pltf_pkg::MIN_TURN_W-1:0]  cfg_wdata_i,
  input  logic                             q_valid_i,
  input  logic [ANGLE_WIDTH-1:0]           q_angle_i,
  input  pltf_pkg::ctl_t                   q_ctl_i,
  input  logic [COORD_WIDTH-1:0]           q_px_i,
  input  logic [COORD_WIDTH-1:0]           q_py_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [COORD_WIDTH-1:0]    out_x_o,
  output logic signed [COORD_WIDTH-1:0]    out_y_o,
  output logic                             keep_o,
  output logic                             out_end_o
);
  import pltf_pkg::*;

  localparam int unsigned CMPW = (ANGLE_WIDTH > MIN_TURN_W) ? ANGLE_WIDTH : MIN_TURN_W;

  logic [MIN_TURN_W-1:0]  min_turn_q;
  logic [ANGLE_WIDTH-1:0] ref_q, ref_d;
  logic [ANGLE_WIDTH-1:0] diff, mag;
  logic                   keep_d;
  logic                   out_valid_q;
  logic [COORD_WIDTH-1:0] out_x_q, out_y_q;
  logic                   keep_q, out_end_q;

  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // The turn magnitude is at most a half turn, which still fits the angle width.
  always_comb begin
    diff   = ref_q - q_angle_i;
    mag    = diff[ANGLE_WIDTH-1] ? (ANGLE_WIDTH'(0) - diff) : diff;
    keep_d = 1'b1;
    ref_d  = ref_q;
    unique case (q_ctl_i.kind)
      KIND_FIRST: begin
        keep_d = 1'b1;
      end
      KIND_SECOND: begin
        ref_d = q_angle_i;
      end
      default: begin
        if (CMPW'(mag) < CMPW'(min_turn_q)) begin
          keep_d = 1'b0;
        end else begin
          ref_d = q_angle_i;
        end
      end
    endcase
    if (q_ctl_i.last) begin
      ref_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_turn_q  <= '0;
      ref_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_turn_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        ref_q       <= ref_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_x_q   <= q_px_i;
      out_y_q   <= q_py_i;
      keep_q    <= keep_d;
      out_end_q <= q_ctl_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign keep_o      = keep_q;
  assign out_end_o   = out_end_q;

endmodule

/* src/polyline_turn_angle_vertex_filter_core.sv */
// Top level of the polyline turn-angle vertex filter: front end, CORDIC
// pipeline, queue and decision stage. Uses pltf_pkg and the pltf_* modules.
//
// The block takes one vertex per cycle while the queue is not full and returns one
// result per vertex, in order, with keep cleared for vertices whose turn from the
// reference direction is below min_turn. The first two vertices of a polygon are
// always kept, and polygon_end resets the state for the next polygon. A vertex passes
// through the front register, 28 CORDIC stages (one vectoring iteration each), the
// queue and the output register. The CORDIC stages and the front advance together
// and stall only while the four-entry queue is full; min_turn should be written only
// while the block is empty.
module polyline_turn_angle_vertex_filter_core #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pltf_pkg::MIN_TURN_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  logic                          polygon_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic                          keep_o,
  output logic                          out_end_o
);
  import pltf_pkg::*;

  localparam int unsigned CW    = COORD_WIDTH + 3;
  localparam int unsigned CTLW  = $bits(ctl_t);
  localparam int unsigned QW    = 2 * COORD_WIDTH + ANGLE_WIDTH + CTLW;

  logic                   adv;
  logic                   s0_valid;
  logic signed [CW-1:0]   s0_x, s0_y;
  logic [ZW-1:0]          s0_z;
  ctl_t                   s0_ctl;
  logic [COORD_WIDTH-1:0] s0_px, s0_py;

  logic                   c_valid;
  logic [ANGLE_WIDTH-1:0] c_angle;
  ctl_t                   c_ctl;
  logic [COORD_WIDTH-1:0] c_px, c_py;

  logic                   q_push, q_pop, q_full, q_not_empty;
  logic [QW-1:0]          q_wdata, q_rdata;
  logic [ANGLE_WIDTH-1:0] q_angle;
  ctl_t                   q_ctl;
  logic [COORD_WIDTH-1:0] q_px, q_py;

  assign adv        = !q_full;
  assign in_ready_o = adv;
  assign q_push     = c_valid && adv;
  assign q_wdata    = {c_px, c_py, c_angle, c_ctl};
  assign {q_px, q_py, q_angle, q_ctl} = q_rdata;

  pltf_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .CW          (CW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .in_valid_i    (in_valid_i),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .polygon_end_i (polygon_end_i),
    .s0_valid_o    (s0_valid),
    .s0_x_o        (s0_x),
    .s0_y_o        (s0_y),
    .s0_z_o        (s0_z),
    .s0_ctl_o      (s0_ctl),
    .s0_px_o       (s0_px),
    .s0_py_o       (s0_py)
  );

  pltf_cordic #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .CW          (CW)
  ) u_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .s0_valid_i (s0_valid),
    .s0_x_i     (s0_x),
    .s0_y_i     (s0_y),
    .s0_z_i     (s0_z),
    .s0_ctl_i   (s0_ctl),
    .s0_px_i    (s0_px),
    .s0_py_i    (s0_py),
    .c_valid_o  (c_valid),
    .c_angle_o  (c_angle),
    .c_ctl_o    (c_ctl),
    .c_px_o     (c_px),
    .c_py_o     (c_py)
  );

  pltf_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .full_o      (q_full),
    .not_empty_o (q_not_empty)
  );

  pltf_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_not_empty),
    .q_angle_i   (q_angle),
    .q_ctl_i     (q_ctl),
    .q_px_i      (q_px),
    .q_py_i      (q_py),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .keep_o      (keep_o),
    .out_end_o   (out_end_o)
  );

endmodule

/* src/pltf_checker.sv */
// Port-level checks for the turn-angle vertex filter, bound to the top level.
// Uses pltf_pkg for the configuration width.
module pltf_checker #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [pltf_pkg::MIN_TURN_W-1:0] cfg_wdata_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [COORD_WIDTH-1:0] out_x_o,
  input logic signed [COORD_WIDTH-1:0] out_y_o,
  input logic                          keep_o,
  input logic                          out_end_o
);
  import pltf_pkg::*;

  logic [1:0]            seen_q;
  logic [MIN_TURN_W-1:0] min_q;
  logic                  out_acc;

  assign out_acc = out_valid_o && out_ready_i;

  // Counts results delivered in the current polygon, saturating at two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 2'd0;
      min_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
      if (out_acc) begin
        if (out_end_o) begin
          seen_q <= 2'd0;
        end else if (seen_q != 2'd2) begin
          seen_q <= seen_q + 2'd1;
        end
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o) && $stable(out_y_o))
    else $error("output result changed while stalled");

  a_first_two_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_q != 2'd2 |-> keep_o)
    else $error("one of the first two vertices of a polygon was dropped");

  a_zero_turn_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && min_q == '0 |-> keep_o)
    else $error("vertex dropped with a zero turn threshold");

  a_keep_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(keep_o) && $stable(out_end_o))
    else $error("keep or end flag changed while stalled");

endmodule

bind polyline_turn_angle_vertex_filter_core pltf_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_pltf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o),
  .keep_o      (keep_o),
  .out_end_o   (out_end_o)
);

/* dv/polyline_turn_angle_vertex_filter_core_tb.sv */
// Self-checking testbench for the polyline turn-angle vertex filter core.
// Drives vertex requests with random gaps and output stalls, and checks each result.
// Depends on pltf_pkg and the RTL under src only.
module polyline_turn_angle_vertex_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pltf_pkg::*;

  localparam int unsigned CW = 32;
  localparam int unsigned AW = 16;
  localparam int unsigned PHASE_ITEMS = 240;
  localparam int unsigned PHASE_COUNT = 8;
  // Idle time after the last expected result has been checked.
  localparam int unsigned DRAIN_CYCLES = 48;
  // Cycle limit for about 2000 requests with their gaps and stalls, plus drains.
  localparam int unsigned LIMIT_CYCLES = 400_000;

  localparam logic signed [CW-1:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;
  localparam logic signed [CW-1:0] EXTREMES [4] = '{CMIN, CMAX, 32'sd0, -32'sd1};

  // atan(2^-i) in 32-bit fractions of a turn.
  localparam logic [31:0] ATAN_STEPS [TURN_ITERS] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005
  };

  typedef struct packed {
    logic                   set_turn;
    logic [MIN_TURN_W-1:0]  turn;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic                   last;
    logic                   has_keep;
    logic                   keep;
  } vertex_row_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 keep;
    logic                 last;
  } vertex_result_t;

  // Directed requests. A row with set_turn first waits for the core to empty and
  // writes min_turn. The keep column is used only where has_keep is set.
  localparam vertex_row_t DIR_ROWS [20] = '{
    // Reset min_turn of zero: every vertex is kept, extremes and a zero vector.
    '{1'b0, 16'h0000, 32'sd0,       32'sd0,       1'b0, 1'b1, 1'b1},
    '{1'b0, 16'h0000, CMAX,         CMAX,         1'b0, 1'b1, 1'b1},
    '{1'b0, 16'h0000, CMIN,         CMIN,         1'b0, 1'b1, 1'b1},
    '{1'b0, 16'h0000, CMIN,         CMIN,         1'b1, 1'b1, 1'b1},
    '{1'b0, 16'h0000, 32'sd5,       32'sd7,       1'b1, 1'b1, 1'b1},
    // Half-turn threshold: straight run dropped, exact reversal kept.
    '{1'b1, 16'h8000, 32'sd0,       32'sd0,       1'b0, 1'b1, 1'b1},
    '{1'b0, 16'h0000, 32'sh10000,   32'sd0,       1'b0, 1'b1, 1'b1},
    '{1'b0, 16'h0000, 32'sh20000,   32'sd0,       1'b0, 1'b1, 1'b0},
    '{1'b0, 16'h0000, 32'sh10000,   32'sd0,       1'b0, 1'b1, 1'b1},
    '{1'b0, 16'h0000, 32'sh10000,   32'sd0,       1'b1, 1'b1, 1'b0},
    // Threshold above a half turn drops every later vertex.
    '{1'b1, 16'hFFFF, 32'sd1,       32'sd2,       1'b0, 1'b1, 1'b1},
    '{1'b0, 16'h0000, -32'sd3,      32'sd4,       1'b0, 1'b1, 1'b1},
    '{1'b0, 16'h0000, 32'sd7,       -32'sd9,      1'b0, 1'b1, 1'b0},
    '{1'b0, 16'h0000, CMIN,         CMAX,         1'b0, 1'b1, 1'b0},
    '{1'b0, 16'h0000, CMAX,         CMIN,         1'b1, 1'b1, 1'b0},
    // Eighth-turn threshold near the diagonal.
    '{1'b1, 16'h2000, 32'sd0,       32'sd0,       1'b0, 1'b1, 1'b1},
    '{1'b0, 16'h0000, 32'sh10000,   32'sd0,       1'b0, 1'b1, 1'b1},
    '{1'b0, 16'h0000, 32'sh20000,   32'sh10000,   1'b0, 1'b0, 1'b0},
    '{1'b0, 16'h0000, 32'sh30000,   32'sh30000,   1'b0, 1'b0, 1'b0},
    '{1'b0, 16'h0000, -32'sh40000,  32'sh50000,   1'b1, 1'b0, 1'b0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [MIN_TURN_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic signed [CW-1:0]  vertex_x_i = '0;
  logic signed [CW-1:0]  vertex_y_i = '0;
  logic                  polygon_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [CW-1:0]  out_x_o;
  logic signed [CW-1:0]  out_y_o;
  logic                  keep_o;
  logic                  out_end_o;

  // Predictor state, mirroring the core.
  kind_e                 next_kind = KIND_FIRST;
  logic signed [CW-1:0]  last_x = '0;
  logic signed [CW-1:0]  last_y = '0;
  logic [AW-1:0]         ref_heading = '0;
  logic [MIN_TURN_W-1:0] min_turn_q = '0;

  vertex_result_t        pending_results [$];
  int unsigned           fail_count = 0;
  int unsigned           cycle_count = 0;
  logic                  no_idle = 1'b0;

  polyline_turn_angle_vertex_filter_core #(
    .COORD_WIDTH (CW),
    .ANGLE_WIDTH (AW)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .polygon_end_i (polygon_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .keep_o        (keep_o),
    .out_end_o     (out_end_o)
  );

  always #10 clk_i = ~clk_i;

  // Direction of the vector (dx, dy) as a binary angle, by CORDIC vectoring.
  function automatic logic [AW-1:0] cordic_heading(input longint dx, input longint dy);
    longint      vx;
    longint      vy;
    longint      sx;
    longint      sy;
    logic [31:0] acc;
    if (dx == 0 && dy == 0) begin
      return '0;
    end
    vx  = dx;
    vy  = dy;
    acc = '0;
    // Fold the left half plane over, adding a half turn.
    if (vx < 0) begin
      vx  = -vx;
      vy  = -vy;
      acc = HALF_TURN;
    end
    for (int i = 0; i < int'(TURN_ITERS); i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy >= 0) begin
        vx  = vx + sy;
        vy  = vy - sx;
        acc = acc + ATAN_STEPS[i];
      end else begin
        vx  = vx - sy;
        vy  = vy + sx;
        acc = acc - ATAN_STEPS[i];
      end
    end
    acc = acc + (32'd1 << (31 - AW));
    return acc[31 -: AW];
  endfunction

  // Decides whether a vertex is kept and advances the predictor state.
  function automatic logic predict_keep(input logic signed [CW-1:0] x,
                                        input logic signed [CW-1:0] y,
                                        input logic last);
    logic [AW-1:0] heading;
    logic [AW-1:0] swing;
    int            mag;
    logic          keep;
    keep = 1'b1;
    if (next_kind == KIND_FIRST) begin
      next_kind = KIND_SECOND;
    end else begin
      heading = cordic_heading(longint'(last_x) - longint'(x),
                               longint'(last_y) - longint'(y));
      if (next_kind == KIND_SECOND) begin
        ref_heading = heading;
        next_kind   = KIND_LATER;
      end else begin
        swing = ref_heading - heading;
        mag   = swing[AW-1] ? (1 << AW) - int'(swing) : int'(swing);
        if (mag < int'(min_turn_q)) begin
          keep = 1'b0;
        end else begin
          ref_heading = heading;
        end
      end
    end
    // The previous point advances even when the vertex is dropped.
    last_x = x;
    last_y = y;
    if (last) begin
      next_kind   = KIND_FIRST;
      last_x      = '0;
      last_y      = '0;
      ref_heading = '0;
    end
    return keep;
  endfunction

  function automatic logic signed [CW-1:0] coord_step();
    logic [31:0] r;
    r = $urandom;
    r = r >> $urandom_range(7, 31);
    return ($urandom_range(0, 1) != 0) ? -$signed(r) : $signed(r);
  endfunction

  // Sends one vertex request and records what the core must return for it.
  task automatic send_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic last, input logic has_keep, input logic keep_given);
    int             gap;
    vertex_result_t exp_res;
    gap = no_idle ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    vertex_x_i    <= x;
    vertex_y_i    <= y;
    polygon_end_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    exp_res.x    = x;
    exp_res.y    = y;
    exp_res.last = last;
    exp_res.keep = predict_keep(x, y, last);
    if (has_keep) begin
      exp_res.keep = keep_given;
    end
    pending_results.insert(pending_results.size(), exp_res);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_min_turn(input logic [MIN_TURN_W-1:0] value);
    wait_for_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    min_turn_q  = value;
  endtask

  // Output side: random stall before each result, with stretches of none.
  initial begin : drain_results
    int stall;
    wait (rst_ni);
    forever begin
      stall = no_idle ? 0 : int'($urandom_range(0, 10));
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    vertex_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: out_x %0h out_y %0h keep %0b", out_x_o, out_y_o, keep_o);
        fail_count++;
      end else begin
        exp_res = pending_results[0];
        pending_results.delete(0);
        if (out_x_o !== exp_res.x) begin
          $error("out_x: expected %0h, got %0h", exp_res.x, out_x_o);
          fail_count++;
        end
        if (out_y_o !== exp_res.y) begin
          $error("out_y: expected %0h, got %0h", exp_res.y, out_y_o);
          fail_count++;
        end
        if (keep_o !== exp_res.keep) begin
          $error("keep: expected %0b, got %0b", exp_res.keep, keep_o);
          fail_count++;
        end
        if (out_end_o !== exp_res.last) begin
          $error("out_end: expected %0b, got %0b", exp_res.last, out_end_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("polyline_turn_angle_vertex_filter_core test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned          n;
    int unsigned          len;
    int unsigned          mode;
    logic                 broken;
    logic                 last;
    logic [MIN_TURN_W-1:0] turn;
    logic signed [CW-1:0] gx;
    logic signed [CW-1:0] gy;
    gx = '0;
    gy = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].set_turn) begin
        set_min_turn(DIR_ROWS[i].turn);
      end
      send_vertex(DIR_ROWS[i].x, DIR_ROWS[i].y, DIR_ROWS[i].last,
                  DIR_ROWS[i].has_keep, DIR_ROWS[i].keep);
    end

    for (int p = 0; p < int'(PHASE_COUNT); p++) begin
      case (p)
        0:       turn = 16'h0000;
        1:       turn = 16'h8000;
        2:       turn = 16'hFFFF;
        3:       turn = 16'h0001;
        4:       turn = 16'h1000;
        6:       turn = 16'd40000;
        default: turn = MIN_TURN_W'($urandom_range(0, 32768));
      endcase
      set_min_turn(turn);
      n = 0;
      while (n < PHASE_ITEMS) begin
        // Mostly short polygons, some long ones; a few carry stray end flags.
        len    = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        broken = ($urandom_range(0, 9) == 0);
        for (int unsigned v = 0; v < len && n < PHASE_ITEMS; v++) begin
          mode = $urandom_range(0, 9);
          if (mode == 0) begin
            gx = $signed($urandom);
            gy = $signed($urandom);
          end else if (mode == 2) begin
            gx = EXTREMES[$urandom_range(0, 3)];
            gy = EXTREMES[$urandom_range(0, 3)];
          end else if (mode != 1) begin
            // Small moves from the previous point give turns near the threshold.
            gx = gx + coord_step();
            gy = gy + coord_step();
          end
          last    = broken ? ($urandom_range(0, 3) == 0) : (v == len - 1);
          no_idle = (n % 64) < 16;
          send_vertex(gx, gy, last, 1'b0, 1'b0);
          n++;
          if (p == 3 && n == PHASE_ITEMS / 2) begin
            wait_for_drain();
          end
        end
      end
      no_idle = 1'b0;
    end

    wait_for_drain();
    if (fail_count == 0) begin
      $display("polyline_turn_angle_vertex_filter_core test passed");
    end else begin
      $display("polyline_turn_angle_vertex_filter_core test failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/pltf_pkg.sv
src/pltf_front.sv
src/pltf_cordic.sv
src/pltf_queue.sv
src/pltf_back.sv
src/polyline_turn_angle_vertex_filter_core.sv
src/pltf_checker.sv
dv/polyline_turn_angle_vertex_filter_core_tb.sv
